// ----- design/brn_pkg.sv -----
// Shared types, constants and lookup functions for the binary to Roman numeral unit.
// No dependencies.
package brn_pkg;

    localparam int VALUE_W  = 12;
    localparam int LETTER_W = 8;
    localparam int DIGIT_W  = 4;
    localparam int PLACES   = 4;
    localparam int PLACE_W  = 2;
    localparam int SYM_W    = 2;

    localparam logic [VALUE_W-1:0] VALUE_MAX = 12'd3999;

    // Reciprocal multipliers: floor(v * K / 2**S) equals floor(v / D) for v below 4096.
    localparam logic [23:0] RECIP_10    = 24'd3277;
    localparam int          SHIFT_10    = 15;
    localparam logic [23:0] RECIP_100   = 24'd1311;
    localparam int          SHIFT_100   = 17;
    localparam logic [23:0] RECIP_1000  = 24'd4195;
    localparam int          SHIFT_1000  = 22;

    localparam logic [LETTER_W-1:0] LETTER_I = 8'h49;
    localparam logic [LETTER_W-1:0] LETTER_V = 8'h56;
    localparam logic [LETTER_W-1:0] LETTER_X = 8'h58;
    localparam logic [LETTER_W-1:0] LETTER_L = 8'h4C;
    localparam logic [LETTER_W-1:0] LETTER_C = 8'h43;
    localparam logic [LETTER_W-1:0] LETTER_D = 8'h44;
    localparam logic [LETTER_W-1:0] LETTER_M = 8'h4D;

    typedef enum logic [SYM_W-1:0] {
        SYM_UNIT = 2'd0,
        SYM_FIVE = 2'd1,
        SYM_TEN  = 2'd2
    } sym_t;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_EMIT = 1'b1
    } state_t;

    typedef struct packed {
        logic load;
        logic step;
    } brn_cmd_t;

    typedef struct packed {
        logic in_nonzero;
        logic final_letter;
    } brn_status_t;

    function automatic logic [2:0] digit_len(input logic [DIGIT_W-1:0] d);
        logic [2:0] n;
        unique case (d)
            4'd1, 4'd5:        n = 3'd1;
            4'd2, 4'd4, 4'd6,
            4'd9:              n = 3'd2;
            4'd3, 4'd7:        n = 3'd3;
            4'd8:              n = 3'd4;
            default:           n = 3'd0;
        endcase
        return n;
    endfunction

    function automatic sym_t digit_sym(input logic [DIGIT_W-1:0] d, input logic [1:0] k);
        sym_t s;
        s = SYM_UNIT;
        if (d == 4'd4 && k == 2'd1) begin
            s = SYM_FIVE;
        end else if (d == 4'd9 && k == 2'd1) begin
            s = SYM_TEN;
        end else if (d >= 4'd5 && d <= 4'd8 && k == 2'd0) begin
            s = SYM_FIVE;
        end
        return s;
    endfunction

    function automatic logic [LETTER_W-1:0] place_letter(input logic [PLACE_W-1:0] p,
                                                         input sym_t s);
        logic [LETTER_W-1:0] c;
        unique case (p)
            2'd0:
            begin
                c = (s == SYM_UNIT) ? LETTER_I : (s == SYM_FIVE) ? LETTER_V : LETTER_X;
            end
            2'd1:
            begin
                c = (s == SYM_UNIT) ? LETTER_X : (s == SYM_FIVE) ? LETTER_L : LETTER_C;
            end
            2'd2:
            begin
                c = (s == SYM_UNIT) ? LETTER_C : (s == SYM_FIVE) ? LETTER_D : LETTER_M;
            end
            default:
            begin
                c = LETTER_M;
            end
        endcase
        return c;
    endfunction

    // Highest place set in the mask.
    function automatic logic [PLACE_W-1:0] top_place(input logic [PLACES-1:0] nz);
        logic [PLACE_W-1:0] p;
        p = '0;
        for (int i = 0; i < PLACES; i++) begin
            if (nz[i]) begin
                p = PLACE_W'(i);
            end
        end
        return p;
    endfunction

    // Mask of the places set in nz that lie strictly below p.
    function automatic logic [PLACES-1:0] below_mask(input logic [PLACES-1:0] nz,
                                                     input logic [PLACE_W-1:0] p);
        logic [PLACES-1:0] m;
        for (int i = 0; i < PLACES; i++) begin
            m[i] = nz[i] && (PLACE_W'(i) < p);
        end
        return m;
    endfunction

endpackage

// ----- design/brn_ctrl.sv -----
// Controller state machine for the binary to Roman numeral unit.
// Depends on brn_pkg.
module brn_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  brn_pkg::brn_status_t status,
    output brn_pkg::brn_cmd_t    cmd,
    output logic                 busy
);
    import brn_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start && status.in_nonzero) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (status.final_letter) begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        cmd.load = 1'b0;
        cmd.step = 1'b0;
        busy     = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.load = start;
            end
            ST_EMIT:
            begin
                cmd.step = 1'b1;
                busy     = 1'b1;
            end
            default:
            begin
                busy = 1'b0;
            end
        endcase
    end

endmodule

// ----- design/brn_datapath.sv -----
// Datapath for the binary to Roman numeral unit: digit split, letter walk and output word.
// Depends on brn_pkg.
module brn_datapath (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic [brn_pkg::VALUE_W-1:0]     value,
    input  brn_pkg::brn_cmd_t               cmd,
    output brn_pkg::brn_status_t            status,
    output logic                            strobe,
    output logic [brn_pkg::LETTER_W-1:0]    letter,
    output logic                            last
);
    import brn_pkg::*;

    logic [VALUE_W-1:0]  sat_value;
    logic [23:0]         prod_10;
    logic [23:0]         prod_100;
    logic [23:0]         prod_1000;
    logic [8:0]          q_10;
    logic [5:0]          q_100;
    logic [1:0]          q_1000;
    logic [VALUE_W-1:0]  rem_0;
    logic [8:0]          rem_1;
    logic [5:0]          rem_2;
    logic [DIGIT_W-1:0]  split_digit [PLACES];
    logic [PLACES-1:0]   split_nz;

    logic [DIGIT_W-1:0]  digit_reg [PLACES];
    logic [PLACES-1:0]   nz_reg;
    logic [PLACE_W-1:0]  place_reg;
    logic [1:0]          k_reg;

    logic [DIGIT_W-1:0]  cur_digit;
    logic [2:0]          cur_len;
    logic                place_done;
    logic [PLACES-1:0]   lower_nz;
    logic                cur_final;
    logic [LETTER_W-1:0] cur_letter;

    logic                strobe_reg;
    logic [LETTER_W-1:0] letter_reg;
    logic                last_reg;

    assign sat_value = (value > VALUE_MAX) ? VALUE_MAX : value;
    assign prod_10   = 24'(sat_value) * RECIP_10;
    assign prod_100  = 24'(sat_value) * RECIP_100;
    assign prod_1000 = 24'(sat_value) * RECIP_1000;
    assign q_10      = prod_10[SHIFT_10+8:SHIFT_10];
    assign q_100     = prod_100[SHIFT_100+5:SHIFT_100];
    assign q_1000    = prod_1000[SHIFT_1000+1:SHIFT_1000];
    assign rem_0     = sat_value - ((12'(q_10) << 3) + (12'(q_10) << 1));
    assign rem_1     = q_10 - ((9'(q_100) << 3) + (9'(q_100) << 1));
    assign rem_2     = q_100 - ((6'(q_1000) << 3) + (6'(q_1000) << 1));

    assign split_digit[0] = rem_0[DIGIT_W-1:0];
    assign split_digit[1] = rem_1[DIGIT_W-1:0];
    assign split_digit[2] = rem_2[DIGIT_W-1:0];
    assign split_digit[3] = {2'b00, q_1000};

    always_comb begin
        for (int i = 0; i < PLACES; i++) begin
            split_nz[i] = (split_digit[i] != '0);
        end
    end

    assign cur_digit  = digit_reg[place_reg];
    assign cur_len    = digit_len(cur_digit);
    assign place_done = ({1'b0, k_reg} == (cur_len - 3'd1));
    assign lower_nz   = below_mask(nz_reg, place_reg);
    assign cur_final  = place_done && (lower_nz == '0);
    assign cur_letter = place_letter(place_reg, digit_sym(cur_digit, k_reg));

    assign status.in_nonzero   = (value != '0);
    assign status.final_letter = cur_final;

    always_ff @(posedge clk) begin
        if (cmd.load) begin
            for (int i = 0; i < PLACES; i++) begin
                digit_reg[i] <= split_digit[i];
            end
            nz_reg    <= split_nz;
            place_reg <= top_place(split_nz);
            k_reg     <= 2'd0;
        end else if (cmd.step) begin
            if (place_done) begin
                place_reg <= top_place(lower_nz);
                k_reg     <= 2'd0;
            end else begin
                k_reg <= k_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            strobe_reg <= 1'b0;
            last_reg   <= 1'b0;
        end else begin
            strobe_reg <= cmd.step;
            last_reg   <= cmd.step && cur_final;
        end
    end

    always_ff @(posedge clk) begin
        if (cmd.step) begin
            letter_reg <= cur_letter;
        end
    end

    assign strobe = strobe_reg;
    assign letter = letter_reg;
    assign last   = last_reg;

endmodule

// ----- design/binary_to_roman_numeral_unit.sv -----
// Binary to Roman numeral unit: one 12-bit number in, its numeral out one letter per word.
// The first letter word follows the accepting edge through the state register and the strobe
// register. While a number's letters are walked busy stays high and no new number is taken;
// the letter walk emits one letter per cycle. A zero value yields no words.
// Reset: rst_n asynchronously returns the controller to idle and drops strobe.
// Depends on brn_pkg, brn_ctrl and brn_datapath.
module binary_to_roman_numeral_unit (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [brn_pkg::VALUE_W-1:0]     value,
    output logic                            busy,
    output logic                            strobe,
    output logic [brn_pkg::LETTER_W-1:0]    letter,
    output logic                            last
);
    import brn_pkg::*;

    brn_cmd_t    cmd;
    brn_status_t status;

    brn_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    brn_datapath u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .value  (value),
        .cmd    (cmd),
        .status (status),
        .strobe (strobe),
        .letter (letter),
        .last   (last)
    );

    a_strobe_follows_busy: assert property (
        @(posedge clk) disable iff (!rst_n) strobe |-> $past(busy)
    ) else $error("letter word without a busy cycle before it");

    a_last_ends_item: assert property (
        @(posedge clk) disable iff (!rst_n) (strobe && last) |-> !busy
    ) else $error("busy still high while the final letter word is shown");

    a_more_letters_pending: assert property (
        @(posedge clk) disable iff (!rst_n) (strobe && !last) |-> busy
    ) else $error("item ended without a final letter word");

    a_zero_value_idle: assert property (
        @(posedge clk) disable iff (!rst_n) (start && !busy && value == '0) |=> (!busy && !strobe)
    ) else $error("zero value produced activity");

endmodule

// ----- bench/binary_to_roman_numeral_unit_tb.sv -----
`timescale 1ns / 1ps
// Testbench for binary_to_roman_numeral_unit: directed and random numbers, letter words checked
// in order against an in-bench numeral predictor. Depends on brn_pkg and the unit itself.
module binary_to_roman_numeral_unit_tb;

    import brn_pkg::*;

    localparam int RANDOM_ITEMS = 380;
    localparam int STALL_LIMIT  = 2000;
    localparam int SETTLE_CYCLES = 24;

    typedef struct {
        logic [LETTER_W-1:0] letter;
        logic                last;
    } letter_word_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   start = 1'b0;
    logic [VALUE_W-1:0]     value = '0;
    logic                   busy;
    logic                   strobe;
    logic [LETTER_W-1:0]    letter;
    logic                   last;

    logic [VALUE_W-1:0]     numbers_to_send[$];
    letter_word_t           expected_letters[$];
    int                     numbers_taken = 0;
    int                     quiet_cycles = 0;
    int                     error_count = 0;

    binary_to_roman_numeral_unit u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .value  (value),
        .busy   (busy),
        .strobe (strobe),
        .letter (letter),
        .last   (last)
    );

    initial
    begin
        forever
        begin
            #6 clk = ~clk;
        end
    end

    task automatic predict_numeral(input logic [VALUE_W-1:0] num);
        int                  rest;
        int                  digit;
        logic [LETTER_W-1:0] unit_l;
        logic [LETTER_W-1:0] five_l;
        logic [LETTER_W-1:0] ten_l;
        logic [LETTER_W-1:0] seq[$];
        letter_word_t        w;
        rest = (num > VALUE_MAX) ? int'(VALUE_MAX) : int'(num);
        for (int place = 3; place >= 0; place--)
        begin
            case (place)
                3:
                begin
                    digit = rest / 1000;
                    unit_l = LETTER_M; five_l = LETTER_M; ten_l = LETTER_M;
                end
                2:
                begin
                    digit = (rest / 100) % 10;
                    unit_l = LETTER_C; five_l = LETTER_D; ten_l = LETTER_M;
                end
                1:
                begin
                    digit = (rest / 10) % 10;
                    unit_l = LETTER_X; five_l = LETTER_L; ten_l = LETTER_C;
                end
                default:
                begin
                    digit = rest % 10;
                    unit_l = LETTER_I; five_l = LETTER_V; ten_l = LETTER_X;
                end
            endcase
            if (digit == 9)
            begin
                seq.push_back(unit_l);
                seq.push_back(ten_l);
            end
            else if (digit == 4)
            begin
                seq.push_back(unit_l);
                seq.push_back(five_l);
            end
            else
            begin
                if (digit >= 5)
                begin
                    seq.push_back(five_l);
                    digit = digit - 5;
                end
                for (int k = 0; k < digit; k++)
                begin
                    seq.push_back(unit_l);
                end
            end
        end
        for (int i = 0; i < seq.size(); i++)
        begin
            w.letter = seq[i];
            w.last   = (i == seq.size() - 1);
            expected_letters.push_back(w);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : driver
        logic taken;
        logic hold_off;
        if (!rst_n)
        begin
            start <= 1'b0;
            value <= '0;
        end
        else
        begin
            taken = start && !busy;
            if (taken)
            begin
                predict_numeral(value);
                numbers_taken++;
            end
            if (!start || taken)
            begin
                hold_off = (numbers_taken >= 150 && numbers_taken < 260) ? 1'b0 :
                           ($urandom_range(0, 99) < 16);
                if (numbers_to_send.size() > 0 && !hold_off)
                begin
                    start <= 1'b1;
                    value <= numbers_to_send.pop_front();
                end
                else
                begin
                    start <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk)
    begin : monitor
        letter_word_t want;
        if (rst_n)
        begin
            if ((start && !busy) || strobe)
            begin
                quiet_cycles <= 0;
            end
            else
            begin
                quiet_cycles <= quiet_cycles + 1;
            end
            if (strobe)
            begin
                if (expected_letters.size() == 0)
                begin
                    $error("unexpected word: letter %h last %b", letter, last);
                    error_count++;
                end
                else
                begin
                    want = expected_letters.pop_front();
                    if (letter !== want.letter)
                    begin
                        $error("letter mismatch: expected %h, actual %h", want.letter, letter);
                        error_count++;
                    end
                    if (last !== want.last)
                    begin
                        $error("last mismatch: expected %b, actual %b", want.last, last);
                        error_count++;
                    end
                end
            end
        end
    end

    initial
    begin : sequencer
        int   pick;
        logic timed_out;
        numbers_to_send = '{12'd0, 12'd1, 12'd4095, 12'd4000, 12'd3999, 12'd3888, 12'd4,
                            12'd9, 12'd5, 12'd40, 12'd90, 12'd400, 12'd900, 12'd1000,
                            12'd3000, 12'd2048, 12'd1994, 12'd444, 12'd999, 12'd3, 12'd8,
                            12'd49, 12'd500, 12'd2730, 12'd1365};
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 4)
            begin
                numbers_to_send.push_back('0);
            end
            else if (pick < 12)
            begin
                numbers_to_send.push_back(VALUE_W'($urandom_range(4000, 4095)));
            end
            else if (pick < 25)
            begin
                numbers_to_send.push_back(VALUE_W'($urandom));
            end
            else
            begin
                numbers_to_send.push_back(VALUE_W'($urandom_range(1, 3999)));
            end
        end
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        while ((numbers_to_send.size() > 0 || start || expected_letters.size() > 0)
               && quiet_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
        end
        timed_out = (quiet_cycles >= STALL_LIMIT);
        if (!timed_out)
        begin
            repeat (SETTLE_CYCLES) @(posedge clk);
        end
        if (timed_out || expected_letters.size() > 0)
        begin
            $display("TB_ERROR");
        end
        else if (error_count == 0)
        begin
            $display("TB_OK");
        end
        else
        begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
design/brn_pkg.sv
design/brn_ctrl.sv
design/brn_datapath.sv
design/binary_to_roman_numeral_unit.sv
bench/binary_to_roman_numeral_unit_tb.sv
